/* hdl/abp_pkg.sv */
package abp_pkg;

  localparam int POS_W      = 16;
  localparam int COLOR_W    = 32;
  localparam int RGB_W      = 24;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_DATA_W-1:0] SCREEN_RESET = 9'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 4'd1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BLEND   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SKIP    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 2'd3;

  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MULT,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic [7:0]       alpha;
    logic [RGB_W-1:0] src;
    logic [RGB_W-1:0] dst;
  } blend_in_t;

endpackage

/* hdl/abp_if.sv */
interface abp_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [abp_pkg::POS_W-1:0]    pos_x;
  logic signed [abp_pkg::POS_W-1:0]    pos_y;
  logic        [abp_pkg::COLOR_W-1:0]  argb_color;

  modport source (output valid, req_type, pos_x, pos_y, argb_color, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, argb_color, output ready);
endinterface

interface abp_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [abp_pkg::COLOR_W-1:0]        pixel_value;
  logic [abp_pkg::STATUS_W-1:0]       status;

  modport source (output valid, pixel_value, status, input ready);
  modport sink   (input valid, pixel_value, status, output ready);
endinterface

interface abp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [abp_pkg::CFG_IDX_W-1:0]       reg_index;
  logic [abp_pkg::CFG_DATA_W-1:0]      wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

/* hdl/abp_store.sv */
module abp_store #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [abp_pkg::RGB_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [abp_pkg::RGB_W-1:0] rd_data
);

  logic [abp_pkg::RGB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/abp_blend.sv */
module abp_blend (
  input  logic                      clk,
  input  logic                      en,
  input  abp_pkg::blend_in_t        operands,
  output logic [abp_pkg::RGB_W-1:0] rgb
);

  logic [15:0] prod_src [3];
  logic [15:0] prod_dst [3];

  // exact floor(p / 255) for p below 65280
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = 17'(p) + 17'(p[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        prod_src[c] <= 16'(operands.src[8*c +: 8]) * 16'(operands.alpha);
        prod_dst[c] <= 16'(operands.dst[8*c +: 8])
                     * 16'(abp_pkg::ALPHA_OPAQUE - operands.alpha);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rgb[8*c +: 8] = div255(prod_src[c]) + div255(prod_dst[c]);
    end
  end

endmodule

/* hdl/alpha_blend_pixel_write.sv */
// Frame store of MAX_WIDTH x MAX_HEIGHT 24-bit pixels with alpha-over blending writes.
// After reset the store is cleared to opaque black by a pass over all MAX_WIDTH*MAX_HEIGHT
// addresses (65536 at the defaults) during which no request is taken; configuration
// writes are taken at any time and must only be issued while the block is idle.
// Pixel (x, y) sits at y * width + x in a single memory with a registered read. A request
// inside the screen passes through accept and address multiply, memory read, channel
// multiplies, and divide-and-sum with write-back; one outside the screen goes from accept
// straight to write-back. Write-back waits while the output register is full; one request
// is in flight at a time, so no request is taken before the last is through. The response
// sits in an output register, so the next request is taken while a finished response waits.
module alpha_blend_pixel_write #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input logic         clk,
  input logic         rst,
  abp_req_if.sink     req,
  abp_rsp_if.source   rsp,
  abp_cfg_if.sink     cfg
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW_RAW = $clog2(MAX_WIDTH + 1);
  localparam int WW     = (WW_RAW > abp_pkg::CFG_DATA_W) ? WW_RAW : abp_pkg::CFG_DATA_W;
  localparam int HW_RAW = $clog2(MAX_HEIGHT + 1);
  localparam int HW     = (HW_RAW > abp_pkg::CFG_DATA_W) ? HW_RAW : abp_pkg::CFG_DATA_W;
  localparam int XL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YL_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PW     = YL_W + WW + 1;

  abp_pkg::state_t state, state_next;

  logic [abp_pkg::CFG_DATA_W-1:0] screen_width;
  logic [abp_pkg::CFG_DATA_W-1:0] screen_height;

  logic [ADDR_W-1:0] clr_cnt;

  logic                         it_type;
  logic                         it_out;
  logic [abp_pkg::COLOR_W-1:0]  it_color;
  logic [ADDR_W-1:0]            it_addr;

  logic                          out_valid;
  logic [abp_pkg::COLOR_W-1:0]   out_pixel;
  logic [abp_pkg::STATUS_W-1:0]  out_status;

  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic           outside;
  logic [PW-1:0]  addr_calc;
  logic           accept;
  logic           out_free;

  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic [abp_pkg::RGB_W-1:0]   wr_data;
  logic                        rd_en;
  logic [abp_pkg::RGB_W-1:0]   rd_data;
  logic                        mult_en;
  logic                        out_load;
  logic [abp_pkg::RGB_W-1:0]   blend_rgb;
  abp_pkg::blend_in_t          blend_in;

  logic [abp_pkg::RGB_W-1:0]     res_rgb;
  logic [abp_pkg::COLOR_W-1:0]   res_pixel;
  logic [abp_pkg::STATUS_W-1:0]  res_status;
  logic                          res_write;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= abp_pkg::SCREEN_RESET;
      screen_height <= abp_pkg::SCREEN_RESET;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        abp_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg.wr_data;
        abp_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg.wr_data;
        default: ;
      endcase
    end
  end

  // bounds and address
  always_comb begin
    w_eff = (WW'(screen_width) < WW'(MAX_WIDTH)) ? WW'(screen_width) : WW'(MAX_WIDTH);
    h_eff = (HW'(screen_height) < HW'(MAX_HEIGHT)) ? HW'(screen_height) : HW'(MAX_HEIGHT);
    outside = req.pos_x[abp_pkg::POS_W-1] || req.pos_y[abp_pkg::POS_W-1]
           || ($unsigned(req.pos_x) >= abp_pkg::POS_W'(w_eff))
           || ($unsigned(req.pos_y) >= abp_pkg::POS_W'(h_eff));
    addr_calc = PW'(req.pos_y[YL_W-1:0]) * PW'(w_eff) + PW'(req.pos_x[XL_W-1:0]);
  end

  assign req.ready = (state == abp_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      it_type  <= req.req_type;
      it_out   <= outside;
      it_color <= req.argb_color;
      it_addr  <= addr_calc[ADDR_W-1:0];
    end
  end

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= abp_pkg::S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == abp_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      abp_pkg::S_CLEAR: begin
        if (clr_cnt == ADDR_W'(DEPTH - 1)) state_next = abp_pkg::S_IDLE;
      end
      abp_pkg::S_IDLE: begin
        if (req.valid) state_next = outside ? abp_pkg::S_WRITE : abp_pkg::S_READ;
      end
      abp_pkg::S_READ:  state_next = abp_pkg::S_MULT;
      abp_pkg::S_MULT:  state_next = abp_pkg::S_WRITE;
      abp_pkg::S_WRITE: begin
        if (out_free) state_next = abp_pkg::S_IDLE;
      end
      default: state_next = abp_pkg::S_CLEAR;
    endcase
  end

  // result selection
  always_comb begin
    res_write  = 1'b0;
    res_rgb    = rd_data;
    res_status = abp_pkg::STAT_OK;
    priority if (it_out) begin
      res_status = abp_pkg::STAT_OUTSIDE;
    end else if (it_type == abp_pkg::REQ_READ) begin
      res_status = abp_pkg::STAT_OK;
    end else if (it_color[31:24] == abp_pkg::ALPHA_CLEAR) begin
      res_status = abp_pkg::STAT_SKIP;
    end else if (it_color[31:24] == abp_pkg::ALPHA_OPAQUE) begin
      res_rgb    = it_color[abp_pkg::RGB_W-1:0];
      res_write  = 1'b1;
    end else begin
      res_rgb    = blend_rgb;
      res_status = abp_pkg::STAT_BLEND;
      res_write  = 1'b1;
    end
    res_pixel = it_out ? '0 : {abp_pkg::ALPHA_OPAQUE, res_rgb};
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = it_addr;
    wr_data  = res_rgb;
    rd_en    = 1'b0;
    mult_en  = 1'b0;
    out_load = 1'b0;
    unique case (state)
      abp_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
      end
      abp_pkg::S_IDLE: ;
      abp_pkg::S_READ:  rd_en   = 1'b1;
      abp_pkg::S_MULT:  mult_en = 1'b1;
      abp_pkg::S_WRITE: begin
        out_load = out_free;
        wr_en    = out_free && res_write;
      end
      default: ;
    endcase
  end

  assign blend_in = '{alpha: it_color[31:24],
                      src:   it_color[abp_pkg::RGB_W-1:0],
                      dst:   rd_data};

  abp_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (it_addr),
    .rd_data (rd_data)
  );

  abp_blend u_blend (
    .clk      (clk),
    .en       (mult_en),
    .operands (blend_in),
    .rgb      (blend_rgb)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel  <= res_pixel;
      out_status <= res_status;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.pixel_value = out_pixel;
  assign rsp.status      = out_status;

endmodule

/* hdl/abp_checker.sv */
module abp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [abp_pkg::COLOR_W-1:0]    rsp_pixel,
  input logic [abp_pkg::STATUS_W-1:0]   rsp_status
);

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request taken right after reset");

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel) && $stable(rsp_status))
    else $error("stalled response changed");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == abp_pkg::STAT_OUTSIDE |-> rsp_pixel == '0)
    else $error("outside response carries a pixel");

  a_inside_opaque: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != abp_pkg::STAT_OUTSIDE
      |-> rsp_pixel[31:24] == abp_pkg::ALPHA_OPAQUE)
    else $error("stored pixel not opaque");

endmodule

bind alpha_blend_pixel_write abp_checker u_abp_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_pixel  (rsp.pixel_value),
  .rsp_status (rsp.status)
);
